// ===== hw/rtl/scfr_pkg.sv =====
`timescale 1ns / 1ps

package scfr_pkg;

  // Default line buffer depth in bytes
  localparam int BUF_DEPTH_DEF = 64;

  // Field widths
  localparam int FLEN_W = 9;  // header + length + checksum + up to 255 bytes
  localparam int LEN_W  = 6;
  localparam int SPD_W  = 16;

  // Frame sync bytes
  localparam logic [7:0] SYNC0 = 8'hAA;
  localparam logic [7:0] SYNC1 = 8'h55;

  // Line terminators
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Command bytes
  localparam logic [7:0] CMD_MOVE    = 8'h01;
  localparam logic [7:0] CMD_STOP    = 8'h02;
  localparam logic [7:0] CMD_MODE    = 8'h03;
  localparam logic [7:0] CMD_STATUS  = 8'h04;
  localparam logic [7:0] CMD_ENC_RST = 8'h05;

  // Highest valid move direction
  localparam logic [7:0] DIR_MAX = 8'h09;

  // Configuration register indexes
  localparam logic CFG_SPEED_MIN = 1'b0;
  localparam logic CFG_SPEED_MAX = 1'b1;

  // Configuration reset values
  localparam logic signed [SPD_W-1:0] SPEED_MIN_RST = 16'sd0;
  localparam logic signed [SPD_W-1:0] SPEED_MAX_RST = 16'sd1000;

  // Result event codes
  typedef enum logic [3:0] {
    EV_MOVE       = 4'd0,
    EV_STOP       = 4'd1,
    EV_MODE_SET   = 4'd2,
    EV_STATUS     = 4'd3,
    EV_ENC_RST    = 4'd4,
    EV_TEXT_LINE  = 4'd5,
    EV_CSUM_ERR   = 4'd6,
    EV_TOO_SHORT  = 4'd7,
    EV_PLEN_ERR   = 4'd8,
    EV_BAD_DIR    = 4'd9,
    EV_BAD_MODE   = 4'd10,
    EV_UNKNOWN    = 4'd11
  } evt_t;

  // One result beat
  typedef struct packed {
    evt_t                     ev;
    logic [7:0]               cmd;
    logic [3:0]               dir;
    logic signed [SPD_W-1:0]  spd;
    logic                     mode;
    logic [LEN_W-1:0]         len;
  } res_t;

endpackage

// ===== hw/rtl/serial_command_frame_receiver.sv =====
`timescale 1ns / 1ps
// A result is registered before it reaches the out_ ports, via the skid stage when held.
// Throughput: one byte per cycle; the output register plus a one-beat skid stage keep
// input acceptance going while a result waits, and in_stall rises only when both are full.
// Reset (synchronous, rst_n low): buffer empty, text mode, control mode 0,
// speed limits 0 and 1000; no clearing pass, the block is ready at once.

module serial_command_frame_receiver
  import scfr_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // received byte channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_rx_byte,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              out_event_res,
  output logic [7:0]              out_command_code,
  output logic [3:0]              out_direction,
  output logic signed [SPD_W-1:0] out_speed,
  output logic                    out_mode_value,
  output logic [LEN_W-1:0]        out_line_length,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [SPD_W-1:0]        cfg_data
);

  localparam int FILL_W = $clog2(BUF_DEPTH + 1);

  // Buffer and frame state
  logic [FILL_W-1:0]       fill_r,  fill_nxt;
  logic                    bin_r,   bin_nxt;
  logic [FLEN_W-1:0]       flen_r,  flen_nxt;
  logic [7:0]              sum_r,   sum_nxt;
  logic                    ctrl_r,  ctrl_nxt;
  logic                    first_aa_r, first_aa_nxt;
  // Captured frame bytes: length, command, first two payload bytes
  logic [7:0]              n_r,    n_nxt;
  logic [7:0]              cmd_r,  cmd_nxt;
  logic [7:0]              pay0_r, pay0_nxt;
  logic [7:0]              pay1_r, pay1_nxt;
  // Speed limits
  logic signed [SPD_W-1:0] spd_min_r, spd_max_r;
  // Output register and skid stage
  logic                    out_valid_r, skid_valid_r;
  res_t                    out_r, skid_r;

  logic                    in_fire, out_fire;
  logic                    full, complete, is_eol, too_long;
  logic [FLEN_W-1:0]       flen_calc;
  logic [7:0]              cur_cmd;
  logic signed [SPD_W-1:0] spd_raw, spd_lo, spd_clamp;
  logic                    res_valid;
  res_t                    res;

  assign in_fire   = in_valid & ~in_stall;
  assign out_fire  = out_valid_r & ~out_stall;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;

  assign full      = (fill_r == FILL_W'(BUF_DEPTH));
  assign is_eol    = (in_rx_byte == CHAR_LF) || (in_rx_byte == CHAR_CR);
  assign flen_calc = FLEN_W'(in_rx_byte) + FLEN_W'(4);
  assign too_long  = (flen_calc > FLEN_W'(BUF_DEPTH));
  assign complete  = bin_r && (flen_r != '0) &&
                     ((FLEN_W'(fill_r) + FLEN_W'(1)) == flen_r);
  // Command byte is the current byte only for an empty frame
  assign cur_cmd   = (fill_r == FILL_W'(3)) ? in_rx_byte : cmd_r;

  // Clamp move speed: lower bound first, then upper; high byte is the last byte
  assign spd_raw   = {in_rx_byte, pay1_r};
  assign spd_lo    = (spd_raw < spd_min_r) ? spd_min_r : spd_raw;
  assign spd_clamp = (spd_lo > spd_max_r) ? spd_max_r : spd_lo;

  // Advance buffer state and decode for one byte
  always_comb begin
    fill_nxt     = fill_r;
    bin_nxt      = bin_r;
    flen_nxt     = flen_r;
    sum_nxt      = sum_r;
    ctrl_nxt     = ctrl_r;
    first_aa_nxt = first_aa_r;
    n_nxt        = n_r;
    cmd_nxt      = cmd_r;
    pay0_nxt     = pay0_r;
    pay1_nxt     = pay1_r;
    res_valid    = 1'b0;
    res.ev       = EV_TEXT_LINE;
    res.cmd      = '0;
    res.dir      = '0;
    res.spd      = '0;
    res.mode     = ctrl_r;
    res.len      = '0;

    if (full) begin
      // drop the byte and restart the buffer
      fill_nxt = '0;
      bin_nxt  = 1'b0;
      flen_nxt = '0;
      sum_nxt  = '0;
    end else begin
      fill_nxt = fill_r + FILL_W'(1);
      if (fill_r >= FILL_W'(2)) begin
        sum_nxt = sum_r + in_rx_byte;
      end

      // capture fixed-position bytes
      if (fill_r == FILL_W'(0)) first_aa_nxt = (in_rx_byte == SYNC0);
      if (fill_r == FILL_W'(2)) n_nxt    = in_rx_byte;
      if (fill_r == FILL_W'(3)) cmd_nxt  = in_rx_byte;
      if (fill_r == FILL_W'(4)) pay0_nxt = in_rx_byte;
      if (fill_r == FILL_W'(5)) pay1_nxt = in_rx_byte;

      // enter binary mode on the sync pair
      if (!bin_r && (fill_r == FILL_W'(1)) && first_aa_r && (in_rx_byte == SYNC1)) begin
        bin_nxt = 1'b1;
      end

      // latch frame length from the length byte
      if (bin_r && (fill_r == FILL_W'(2))) begin
        flen_nxt = flen_calc;
        if (too_long) begin
          fill_nxt = '0;
          bin_nxt  = 1'b0;
          flen_nxt = '0;
          sum_nxt  = '0;
        end
      end

      if (complete) begin
        res_valid = 1'b1;
        res.cmd   = cur_cmd;
        if (n_r == 8'd0) begin
          res.ev = EV_TOO_SHORT;
        end else if (sum_r != in_rx_byte) begin
          res.ev = EV_CSUM_ERR;
        end else begin
          case (cur_cmd)
            CMD_MOVE: begin
              if (n_r != 8'd3) begin
                res.ev = EV_PLEN_ERR;
              end else if (pay0_r <= DIR_MAX) begin
                res.ev  = EV_MOVE;
                res.dir = pay0_r[3:0];
                res.spd = spd_clamp;
              end else begin
                res.ev  = EV_BAD_DIR;
                res.spd = spd_clamp;
              end
            end
            CMD_STOP: begin
              res.ev = (n_r != 8'd1) ? EV_PLEN_ERR : EV_STOP;
            end
            CMD_MODE: begin
              if (n_r != 8'd2) begin
                res.ev = EV_PLEN_ERR;
              end else if (pay0_r <= 8'd1) begin
                res.ev   = EV_MODE_SET;
                ctrl_nxt = pay0_r[0];
                res.mode = pay0_r[0];
              end else begin
                res.ev = EV_BAD_MODE;
              end
            end
            CMD_STATUS: begin
              res.ev = (n_r != 8'd1) ? EV_PLEN_ERR : EV_STATUS;
            end
            CMD_ENC_RST: begin
              res.ev = (n_r != 8'd1) ? EV_PLEN_ERR : EV_ENC_RST;
            end
            default: begin
              res.ev = EV_UNKNOWN;
            end
          endcase
        end
        fill_nxt = '0;
        bin_nxt  = 1'b0;
        flen_nxt = '0;
        sum_nxt  = '0;
      end else if (!bin_r && is_eol) begin
        // end of text line; length excludes the terminator
        res_valid = 1'b1;
        res.ev    = EV_TEXT_LINE;
        res.len   = LEN_W'(fill_r);
        fill_nxt  = '0;
        bin_nxt   = 1'b0;
        flen_nxt  = '0;
        sum_nxt   = '0;
      end
    end
  end

  // Hold buffer state; advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      bin_r      <= 1'b0;
      flen_r     <= '0;
      sum_r      <= '0;
      ctrl_r     <= 1'b0;
      first_aa_r <= 1'b0;
    end else if (in_fire) begin
      fill_r     <= fill_nxt;
      bin_r      <= bin_nxt;
      flen_r     <= flen_nxt;
      sum_r      <= sum_nxt;
      ctrl_r     <= ctrl_nxt;
      first_aa_r <= first_aa_nxt;
    end
  end

  // Capture frame bytes
  always_ff @(posedge clk) begin
    if (in_fire) begin
      n_r    <= n_nxt;
      cmd_r  <= cmd_nxt;
      pay0_r <= pay0_nxt;
      pay1_r <= pay1_nxt;
    end
  end

  // Write speed limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_min_r <= SPEED_MIN_RST;
      spd_max_r <= SPEED_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPEED_MIN: spd_min_r <= cfg_data;
        CFG_SPEED_MAX: spd_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_fire) begin
      out_valid_r <= in_fire && res_valid;
    end else if (in_fire && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Move payload along with the valid bits
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (!out_valid_r || out_fire) out_r <= skid_r;
    end else if (!out_valid_r || out_fire) begin
      out_r <= res;
    end else if (in_fire && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_r.ev;
  assign out_command_code = out_r.cmd;
  assign out_direction    = out_r.dir;
  assign out_speed        = out_r.spd;
  assign out_mode_value   = out_r.mode;
  assign out_line_length  = out_r.len;

  // Skid stage only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full with output register empty");

  // Fill count never passes the buffer depth
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(BUF_DEPTH))
    else $error("fill count beyond buffer depth");

  // Binary mode only after the sync pair is in the buffer
  a_bin_fill: assert property (@(posedge clk) disable iff (!rst_n)
    bin_r |-> (fill_r >= FILL_W'(2)))
    else $error("binary mode with fewer than two bytes buffered");

  // A latched frame length fits the buffer and is not yet reached
  a_flen_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (flen_r != '0) |-> (bin_r && (flen_r <= FLEN_W'(BUF_DEPTH)) &&
                        (FLEN_W'(fill_r) < flen_r)))
    else $error("frame length out of range");

  // A mode set beat takes the mode byte into the control select
  a_mode_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && complete && res_valid && (res.ev == EV_MODE_SET)) |=>
      (ctrl_r == $past(pay0_r[0])))
    else $error("control select not updated by mode set");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import scfr_pkg::*;

  localparam int LONG_HOLD = 80;
  localparam logic [7:0] KNOWN_CMDS [5] = '{CMD_MOVE, CMD_STOP, CMD_MODE, CMD_STATUS,
                                            CMD_ENC_RST};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [3:0]        out_event_res;
  logic [7:0]        out_command_code;
  logic [3:0]        out_direction;
  logic signed [SPD_W-1:0] out_speed;
  logic              out_mode_value;
  logic [LEN_W-1:0]  out_line_length;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_SPEED_MIN;
  logic [SPD_W-1:0]  cfg_data = '0;

  serial_command_frame_receiver uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_command_code (out_command_code),
    .out_direction    (out_direction),
    .out_speed        (out_speed),
    .out_mode_value   (out_mode_value),
    .out_line_length  (out_line_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to go out and event beats waiting to come back
  logic [7:0] tx_bytes [$];
  res_t       awaited_events [$];

  int  errors = 0;
  int  bytes_accepted = 0;
  int  results_checked = 0;
  int  event_seen [16];
  bit  send_gaps = 1'b1;
  bit  recv_gaps = 1'b1;
  int  hold_requests = 0;
  int  hold_served = 0;

  // Shadow copy of the receiver state
  logic [7:0]         line_buf [BUF_DEPTH_DEF];
  int unsigned        fill_cnt = 0;
  bit                 in_binary = 1'b0;
  int unsigned        frame_len = 0;
  logic [7:0]         byte_sum = 8'h00;
  logic               ctl_mode = 1'b0;
  logic signed [15:0] speed_lo = SPEED_MIN_RST;
  logic signed [15:0] speed_hi = SPEED_MAX_RST;

  function automatic void clear_line();
    fill_cnt  = 0;
    in_binary = 1'b0;
    frame_len = 0;
    byte_sum  = 8'h00;
  endfunction

  function automatic res_t make_result(evt_t ev, logic [7:0] cmd, logic [3:0] dir,
                                       logic signed [15:0] spd, logic [5:0] len);
    res_t r;
    r.ev   = ev;
    r.cmd  = cmd;
    r.dir  = dir;
    r.spd  = spd;
    r.mode = ctl_mode;
    r.len  = len;
    return r;
  endfunction

  // Decode a frame whose checksum matched
  function automatic res_t decode_frame(int unsigned n);
    logic [7:0]         cmd;
    logic signed [15:0] spd;
    cmd = line_buf[3];
    case (cmd)
      CMD_MOVE: begin
        if (n != 3) return make_result(EV_PLEN_ERR, cmd, 4'd0, 16'sd0, 6'd0);
        spd = {line_buf[6], line_buf[5]};
        if (spd < speed_lo) spd = speed_lo;
        if (spd > speed_hi) spd = speed_hi;
        if (line_buf[4] <= DIR_MAX) return make_result(EV_MOVE, cmd, line_buf[4][3:0], spd, 6'd0);
        return make_result(EV_BAD_DIR, cmd, 4'd0, spd, 6'd0);
      end
      CMD_STOP: begin
        if (n != 1) return make_result(EV_PLEN_ERR, cmd, 4'd0, 16'sd0, 6'd0);
        return make_result(EV_STOP, cmd, 4'd0, 16'sd0, 6'd0);
      end
      CMD_MODE: begin
        if (n != 2) return make_result(EV_PLEN_ERR, cmd, 4'd0, 16'sd0, 6'd0);
        if (line_buf[4] > 8'd1) return make_result(EV_BAD_MODE, cmd, 4'd0, 16'sd0, 6'd0);
        ctl_mode = line_buf[4][0];
        return make_result(EV_MODE_SET, cmd, 4'd0, 16'sd0, 6'd0);
      end
      CMD_STATUS: begin
        if (n != 1) return make_result(EV_PLEN_ERR, cmd, 4'd0, 16'sd0, 6'd0);
        return make_result(EV_STATUS, cmd, 4'd0, 16'sd0, 6'd0);
      end
      CMD_ENC_RST: begin
        if (n != 1) return make_result(EV_PLEN_ERR, cmd, 4'd0, 16'sd0, 6'd0);
        return make_result(EV_ENC_RST, cmd, 4'd0, 16'sd0, 6'd0);
      end
      default: return make_result(EV_UNKNOWN, cmd, 4'd0, 16'sd0, 6'd0);
    endcase
  endfunction

  // Advance the shadow state by one byte; returns 1 when an event is due
  function automatic bit parse_byte(input logic [7:0] b, output res_t r);
    logic [7:0]  prior;
    int unsigned n;
    prior = byte_sum;
    r = '0;
    if (fill_cnt < BUF_DEPTH_DEF) begin
      line_buf[fill_cnt] = b;
      if (fill_cnt >= 2) byte_sum += b;
      fill_cnt++;
    end else begin
      clear_line();
    end
    if (!in_binary && fill_cnt >= 2 && line_buf[0] == SYNC0 && line_buf[1] == SYNC1)
      in_binary = 1'b1;
    if (in_binary && frame_len == 0 && fill_cnt >= 3) begin
      frame_len = 4 + line_buf[2];
      if (frame_len > BUF_DEPTH_DEF) clear_line();
    end
    if (in_binary && frame_len > 0 && fill_cnt >= frame_len) begin
      n = line_buf[2];
      if (n == 0)
        r = make_result(EV_TOO_SHORT, line_buf[3], 4'd0, 16'sd0, 6'd0);
      else if (prior != line_buf[(3 + n) % BUF_DEPTH_DEF])
        r = make_result(EV_CSUM_ERR, line_buf[3], 4'd0, 16'sd0, 6'd0);
      else
        r = decode_frame(n);
      clear_line();
      return 1'b1;
    end
    if (!in_binary && (b == CHAR_LF || b == CHAR_CR) && fill_cnt > 0) begin
      n = fill_cnt - 1;
      clear_line();
      r = make_result(EV_TEXT_LINE, 8'h00, 4'd0, 16'sd0, n[5:0]);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Binary frame with N = body_len + 1; body bytes past the second are random
  function automatic void queue_frame(logic [7:0] cmd, int body_len, logic [7:0] b0,
                                      logic [7:0] b1, bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'(body_len + 1) + cmd;
    tx_bytes.push_back(SYNC0);
    tx_bytes.push_back(SYNC1);
    tx_bytes.push_back(8'(body_len + 1));
    tx_bytes.push_back(cmd);
    for (int i = 0; i < body_len; i++) begin
      b = (i == 0) ? b0 : (i == 1) ? b1 : 8'($urandom);
      tx_bytes.push_back(b);
      sum += b;
    end
    tx_bytes.push_back(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
  endfunction

  // Header with N = 0: the fourth byte closes the frame
  function automatic void queue_empty_frame(logic [7:0] last);
    tx_bytes.push_back(SYNC0);
    tx_bytes.push_back(SYNC1);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(last);
  endfunction

  // Header whose length cannot fit the buffer
  function automatic void queue_oversize(logic [7:0] n);
    tx_bytes.push_back(SYNC0);
    tx_bytes.push_back(SYNC1);
    tx_bytes.push_back(n);
  endfunction

  // Text line of random bytes, kept clear of terminators and of a sync start
  function automatic void queue_text(int len, logic [7:0] term);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (b == CHAR_LF || b == CHAR_CR || (i == 0 && b == SYNC0)) b ^= 8'h40;
      tx_bytes.push_back(b);
    end
    tx_bytes.push_back(term);
  endfunction

  // Byte driver: predict on each accepted beat, then offer the next byte
  always @(posedge clk) begin : drive_bytes
    res_t outcome;
    int   send_wait;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (parse_byte(in_rx_byte, outcome)) awaited_events.push_back(outcome);
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() > 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= tx_bytes.pop_front();
          if (send_gaps) send_wait = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result back-pressure: random stalls plus requested long holds
  always @(posedge clk) begin : drive_stall
    int stall_left;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      stall_left  = LONG_HOLD;
      out_stall  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (recv_gaps && $urandom_range(0, 99) < 30) begin
      stall_left = pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_events.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got event %0d",
                 $time, out_event_res);
        errors++;
      end else begin
        want = awaited_events.pop_front();
        check_field("event", 16'(want.ev), 16'(out_event_res));
        check_field("command", 16'(want.cmd), 16'(out_command_code));
        check_field("direction", 16'(want.dir), 16'(out_direction));
        check_field("speed", want.spd, out_speed);
        check_field("mode", 16'(want.mode), 16'(out_mode_value));
        check_field("line length", 16'(want.len), 16'(out_line_length));
        results_checked++;
        event_seen[out_event_res]++;
      end
    end
  end

  // Hold the sender until every predicted beat has come back
  task automatic wait_drain();
    do @(negedge clk); while (tx_bytes.size() != 0 || in_valid || awaited_events.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic signed [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SPEED_MIN) speed_lo = val;
    else speed_hi = val;
  endtask

  initial begin : stimulus
    int                 pick;
    int                 blen;
    int                 target;
    int                 kinds;
    logic [7:0]         cmd;
    logic [7:0]         b0;
    logic signed [15:0] lim_lo;
    logic signed [15:0] lim_hi;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: text lines, buffer overflow, every command and error path
    queue_text(0, CHAR_CR);
    queue_text(2, CHAR_LF);
    queue_text(63, CHAR_LF);
    queue_text(64, CHAR_CR);
    queue_text(0, CHAR_LF);
    queue_frame(CMD_MOVE, 2, 8'd0, 8'hFF, 1'b0);
    queue_frame(CMD_MOVE, 2, DIR_MAX, 8'h10, 1'b0);
    queue_frame(CMD_MOVE, 2, 8'd10, 8'h80, 1'b0);
    queue_frame(CMD_MOVE, 2, 8'hFF, 8'h00, 1'b0);
    queue_frame(CMD_STOP, 0, 8'h00, 8'h00, 1'b0);
    queue_frame(CMD_MODE, 1, 8'd1, 8'h00, 1'b0);
    queue_frame(CMD_MODE, 1, 8'd2, 8'h00, 1'b0);
    queue_frame(CMD_MODE, 1, 8'd0, 8'h00, 1'b0);
    queue_frame(CMD_STATUS, 0, 8'h00, 8'h00, 1'b0);
    queue_frame(CMD_ENC_RST, 0, 8'h00, 8'h00, 1'b0);
    queue_frame(8'h00, 0, 8'h00, 8'h00, 1'b0);
    queue_frame(8'hFF, 2, 8'hFF, 8'h00, 1'b0);
    queue_frame(CMD_STOP, 1, 8'h00, 8'h00, 1'b0);
    queue_frame(CMD_MOVE, 1, 8'd3, 8'h00, 1'b0);
    queue_frame(CMD_MODE, 0, 8'h00, 8'h00, 1'b0);
    queue_frame(CMD_STATUS, 2, 8'h00, 8'h00, 1'b0);
    queue_frame(CMD_ENC_RST, 3, 8'h00, 8'h00, 1'b0);
    queue_empty_frame(8'hFF);
    queue_frame(CMD_STOP, 0, 8'h00, 8'h00, 1'b1);
    queue_oversize(8'd61);
    queue_frame(8'h80, 59, 8'h00, 8'hFF, 1'b0);
    queue_oversize(8'hFF);
    wait_drain();

    // Speed limits at both extremes, then crossed
    write_reg(CFG_SPEED_MIN, 16'sh8000);
    write_reg(CFG_SPEED_MAX, 16'sh7FFF);
    for (int i = 0; i < 4; i++) queue_frame(CMD_MOVE, 2, 8'(i * 3), 8'($urandom), 1'b0);
    wait_drain();
    write_reg(CFG_SPEED_MIN, 16'sh7FFF);
    write_reg(CFG_SPEED_MAX, 16'sh8000);
    for (int i = 0; i < 3; i++) queue_frame(CMD_MOVE, 2, 8'(i), 8'($urandom), 1'b0);
    wait_drain();

    // Long receiver hold against a burst of one-byte lines, each giving a beat
    send_gaps = 1'b0;
    hold_requests++;
    @(negedge clk);
    repeat (20) queue_text(1, CHAR_CR);
    wait_drain();

    // Random phases, each with its own speed limits
    target = bytes_accepted;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin lim_lo = SPEED_MIN_RST; lim_hi = SPEED_MAX_RST; end
        1: begin lim_lo = 16'sh8000; lim_hi = 16'sh7FFF; end
        2: begin lim_lo = -16'sd200; lim_hi = 16'sd200; end
        default: begin
          lim_lo = 16'($urandom);
          lim_hi = 16'($urandom);
        end
      endcase
      write_reg(CFG_SPEED_MIN, lim_lo);
      write_reg(CFG_SPEED_MAX, lim_hi);
      send_gaps = (phase != 0);
      recv_gaps = (phase != 0);
      target += 135;
      while (bytes_accepted + tx_bytes.size() < target) begin
        while (tx_bytes.size() > 4) @(negedge clk);
        if (phase != 0 && $urandom_range(0, 19) == 0) begin
          send_gaps = !send_gaps;
          recv_gaps = !recv_gaps;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // well-formed known command, random content
          cmd = KNOWN_CMDS[$urandom_range(0, 4)];
          blen = (cmd == CMD_MOVE) ? 2 : (cmd == CMD_MODE) ? 1 : 0;
          if (cmd == CMD_MOVE)
            b0 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
          else
            b0 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
          queue_frame(cmd, blen, b0, 8'($urandom), $urandom_range(0, 9) == 0);
        end else if (pick < 76) begin
          // known command with a wrong payload length
          cmd = KNOWN_CMDS[$urandom_range(0, 4)];
          blen = (cmd == CMD_MOVE) ? 2 : (cmd == CMD_MODE) ? 1 : 0;
          blen = (blen + $urandom_range(1, 4)) % 6;
          queue_frame(cmd, blen, 8'($urandom), 8'($urandom), 1'b0);
        end else if (pick < 80) begin
          do cmd = 8'($urandom); while (cmd >= CMD_MOVE && cmd <= CMD_ENC_RST);
          blen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 59) : $urandom_range(0, 6);
          queue_frame(cmd, blen, 8'($urandom), 8'($urandom), $urandom_range(0, 4) == 0);
        end else if (pick < 83) begin
          queue_empty_frame(8'($urandom));
        end else if (pick < 86) begin
          queue_oversize(8'($urandom_range(61, 255)));
        end else if (pick < 95) begin
          queue_text($urandom_range(0, 20), $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        end else if (pick < 99) begin
          // raw noise, sometimes closed off by a line feed
          repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom));
          if ($urandom_range(0, 1)) tx_bytes.push_back(CHAR_LF);
        end else begin
          queue_text(64 + $urandom_range(0, 3), CHAR_LF);
        end
        if ($urandom_range(0, 33) == 0) wait_drain();
      end
      wait_drain();
    end

    kinds = 0;
    foreach (event_seen[k]) if (event_seen[k] > 0) kinds++;
    $display("Run covered %0d bytes and %0d checked result beats across %0d event kinds,",
             bytes_accepted, results_checked, kinds);
    $display("with five speed-limit settings, random gaps and a long result hold.");
    if (errors == 0 && awaited_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/scfr_pkg.sv
hw/rtl/serial_command_frame_receiver.sv
tb/sv/testbench.sv
